@@ rtl/apmc_pkg.sv @@
// Package for the auto-incrementing pointer memory card.
// Holds operation codes, register indexes, field widths and ROM offsets.
// No dependencies.
package apmc_pkg;

	localparam int unsigned OPCODE_W   = 2;
	localparam int unsigned ADDR_W     = 11;
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned ROM_ADDR_W = 13;
	localparam int unsigned REG_IDX_W  = 4;
	localparam int unsigned PTR_W      = 24;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned SLOT_W     = 3;

	// bus operations
	typedef enum logic [OPCODE_W-1:0] {
		OP_REG_RD   = 2'd0,
		OP_REG_WR   = 2'd1,
		OP_SLOT_ROM = 2'd2,
		OP_EXP_ROM  = 2'd3
	} op_t;

	// register window
	localparam logic [REG_IDX_W-1:0] REG_PTR_LO  = 4'd0;
	localparam logic [REG_IDX_W-1:0] REG_PTR_MID = 4'd1;
	localparam logic [REG_IDX_W-1:0] REG_PTR_HI  = 4'd2;
	localparam logic [REG_IDX_W-1:0] REG_RAM     = 4'd3;
	localparam logic [REG_IDX_W-1:0] REG_BANK    = 4'd15;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BANK_HIGH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ALT_MODE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOT      = 2'd2;

	localparam logic [BYTE_W-1:0] BANK_HIGH_RST = 8'hF0;
	localparam logic [SLOT_W-1:0] SLOT_RST      = 3'd1;
	localparam logic [BYTE_W-1:0] RAM_FILL      = 8'hFF;

	// ROM map
	localparam logic [ROM_ADDR_W-1:0] SLOT_BANK_OFS = 13'h1000;
	localparam logic [ROM_ADDR_W-1:0] EXP_ROM_BASE  = 13'h0800;
	localparam logic [ROM_ADDR_W-1:0] EXP_BANK_BASE = 13'h1800;

	// command from the bus decoder to the register window
	typedef struct packed {
		logic                 wr;   // plain register or pointer byte write
		logic                 adv;  // data port access, bump live pointer
		logic [REG_IDX_W-1:0] idx;
		logic [BYTE_W-1:0]    data;
	} reg_cmd_t;

endpackage

@@ rtl/apmc_ifs.sv @@
// Handshake channels of the memory card: bus request and bus response.
// Depends on apmc_pkg.
interface apmc_req_if import apmc_pkg::*; ();
	logic              valid;
	logic              ready;
	op_t               opcode;
	logic [ADDR_W-1:0] address;
	logic [BYTE_W-1:0] write_data;

	modport source(output valid, opcode, address, write_data, input ready);
	modport sink(input valid, opcode, address, write_data, output ready);
endinterface

interface apmc_rsp_if import apmc_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [BYTE_W-1:0]     read_data;
	logic [ROM_ADDR_W-1:0] rom_address;
	logic                  rom_valid;

	modport source(output valid, read_data, rom_address, rom_valid, input ready);
	modport sink(input valid, read_data, rom_address, rom_valid, output ready);
endinterface

@@ rtl/apmc_ram.sv @@
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module apmc_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

@@ rtl/apmc_regs.sv @@
// Register window of the memory card: base and live pointers, pointer mirror
// bytes, plain storage bytes. Depends on apmc_pkg.
module apmc_regs import apmc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  reg_cmd_t          cmd,
	input  logic [BYTE_W-1:0] bank_high_bits,
	output logic [PTR_W-1:0]  live_ptr,
	output logic [BYTE_W-1:0] rd_byte,
	output logic              bank_bit
);

	logic [PTR_W-1:0]  base_q;
	logic [PTR_W-1:0]  live_q;
	logic [BYTE_W-1:0] regs_q [16];
	logic [PTR_W-1:0]  base_nxt;
	logic [PTR_W-1:0]  live_inc;

	// byte insert into the base pointer
	always_comb begin
		base_nxt = base_q;
		case (cmd.idx)
			REG_PTR_LO:  base_nxt[7:0]   = cmd.data;
			REG_PTR_MID: base_nxt[15:8]  = cmd.data;
			REG_PTR_HI:  base_nxt[23:16] = cmd.data;
			default:     base_nxt        = base_q;
		endcase
	end

	assign live_inc = live_q + PTR_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			live_q <= '0;
			for (int i = 0; i < 16; i++) begin
				regs_q[i] <= '0;
			end
		end else if (cmd.adv) begin
			// data port access: step the live pointer and refresh the mirror
			live_q              <= live_inc;
			regs_q[REG_PTR_LO]  <= live_inc[7:0];
			regs_q[REG_PTR_MID] <= live_inc[15:8];
			regs_q[REG_PTR_HI]  <= live_inc[23:16] | bank_high_bits;
		end else if (cmd.wr) begin
			if (cmd.idx <= REG_PTR_HI) begin
				base_q              <= base_nxt;
				live_q              <= base_nxt;
				regs_q[REG_PTR_LO]  <= base_nxt[7:0];
				regs_q[REG_PTR_MID] <= base_nxt[15:8];
				regs_q[REG_PTR_HI]  <= base_nxt[23:16] | bank_high_bits;
			end else begin
				regs_q[cmd.idx] <= cmd.data;
			end
		end
	end

	assign live_ptr = live_q;
	assign rd_byte  = regs_q[cmd.idx];
	assign bank_bit = regs_q[REG_BANK][0];

endmodule

@@ rtl/autoinc_pointer_memory_card.sv @@
// Auto-incrementing pointer RAM expansion card, bus side.
// Requests arrive as words on the req channel (opcode, address, write_data) and
// each gives exactly one word on the rsp channel (read_data, rom_address,
// rom_valid), in order. Configuration goes in through cfg_we/cfg_idx/cfg_wdata;
// the user must write it only while no request is outstanding, which the card
// itself does not enforce. Register writes, register reads other than the data
// port and ROM requests have their response word registered in the cycle after
// acceptance; a read of the data port (register 3) passes through ST_RAM_RD for
// the registered read of the card RAM. Throughput is one request per cycle while
// the receiver takes words; a data port read holds requests back in ST_RAM_RD.
// The response register frees in the same cycle it is taken, so a new request
// is accepted while the previous word is being handed over; if the receiver
// stalls, the word holds and req.ready stays low.
// After reset the card RAM is filled with 0xFF, one byte per cycle, through all
// of its addresses; req.ready stays low meanwhile, configuration writes are
// still taken. Pointers, register window and configuration reset at once.
// Depends on apmc_pkg, apmc_ifs, apmc_ram and apmc_regs.
module autoinc_pointer_memory_card import apmc_pkg::*; #(
	parameter int unsigned RAM_ADDR_BITS = 20
) (
	input  logic                 clk,
	input  logic                 arst_n,
	apmc_req_if.sink             req,
	apmc_rsp_if.source           rsp,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [BYTE_W-1:0]    cfg_wdata
);

	localparam int unsigned RAM_DEPTH = 1 << RAM_ADDR_BITS;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RAM_RD
	} state_t;

	state_t                    state_q;
	logic [RAM_ADDR_BITS-1:0]  clr_cnt_q;
	logic                      out_valid_q;
	logic [BYTE_W-1:0]         read_data_q;
	logic [ROM_ADDR_W-1:0]     rom_address_q;
	logic                      rom_valid_q;

	logic [BYTE_W-1:0]         bank_high_q;
	logic                      alt_mode_q;
	logic [SLOT_W-1:0]         slot_q;

	logic                      accept;
	logic                      rsp_take;
	logic [REG_IDX_W-1:0]      reg_idx;
	logic                      data_port;
	logic                      ram_rd_req;
	logic                      bank_sw;
	reg_cmd_t                  cmd;
	logic [PTR_W-1:0]          live_ptr;
	logic [BYTE_W-1:0]         rd_byte;
	logic                      bank_bit;

	logic                      ram_we;
	logic [RAM_ADDR_BITS-1:0]  ram_addr;
	logic [BYTE_W-1:0]         ram_wdata;
	logic [BYTE_W-1:0]         ram_rdata;

	logic [BYTE_W-1:0]         res_rd;
	logic [ROM_ADDR_W-1:0]     res_rom;
	logic                      res_rom_vld;

	// handshakes
	assign rsp_take  = out_valid_q & rsp.ready;
	assign req.ready = (state_q == ST_IDLE) & (~out_valid_q | rsp.ready);
	assign accept    = req.valid & req.ready;

	assign reg_idx    = req.address[REG_IDX_W-1:0];
	assign data_port  = (reg_idx == REG_RAM);
	assign ram_rd_req = accept & (req.opcode == OP_REG_RD) & data_port;
	assign bank_sw    = alt_mode_q & bank_bit;

	// register window command
	always_comb begin
		cmd.wr   = accept & (req.opcode == OP_REG_WR) & ~data_port;
		cmd.adv  = accept & data_port
			& ((req.opcode == OP_REG_RD) | (req.opcode == OP_REG_WR));
		cmd.idx  = reg_idx;
		cmd.data = req.write_data;
	end

	apmc_regs u_regs (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.bank_high_bits (bank_high_q),
		.live_ptr       (live_ptr),
		.rd_byte        (rd_byte),
		.bank_bit       (bank_bit)
	);

	// RAM port: clearing pass after reset, then data port accesses
	always_comb begin
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_addr  = clr_cnt_q;
			ram_wdata = RAM_FILL;
		end else begin
			ram_we    = accept & (req.opcode == OP_REG_WR) & data_port;
			ram_addr  = live_ptr[RAM_ADDR_BITS-1:0];
			ram_wdata = req.write_data;
		end
	end

	apmc_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (RAM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// response word for everything except data port reads
	always_comb begin
		res_rd      = '0;
		res_rom     = '0;
		res_rom_vld = 1'b0;
		case (req.opcode)
			OP_REG_RD: begin
				res_rd = rd_byte;
			end
			OP_REG_WR: begin
				res_rd = '0;
			end
			OP_SLOT_ROM: begin
				res_rom     = ROM_ADDR_W'({slot_q, req.address[7:0]})
					+ (bank_sw ? SLOT_BANK_OFS : '0);
				res_rom_vld = 1'b1;
			end
			OP_EXP_ROM: begin
				res_rom     = ROM_ADDR_W'(req.address)
					+ (bank_sw ? EXP_BANK_BASE : EXP_ROM_BASE);
				res_rom_vld = 1'b1;
			end
			default: begin
				res_rd = '0;
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_high_q <= BANK_HIGH_RST;
			alt_mode_q  <= 1'b0;
			slot_q      <= SLOT_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_BANK_HIGH: bank_high_q <= cfg_wdata;
				CFG_ALT_MODE:  alt_mode_q  <= cfg_wdata[0];
				CFG_SLOT:      slot_q      <= cfg_wdata[SLOT_W-1:0];
				default:       bank_high_q <= bank_high_q;
			endcase
		end
	end

	// sequencer and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			clr_cnt_q     <= '0;
			out_valid_q   <= 1'b0;
			read_data_q   <= '0;
			rom_address_q <= '0;
			rom_valid_q   <= 1'b0;
		end else begin
			if (rsp_take) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + RAM_ADDR_BITS'(1);
					if (&clr_cnt_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (ram_rd_req) begin
						state_q <= ST_RAM_RD;
					end else if (accept) begin
						out_valid_q   <= 1'b1;
						read_data_q   <= res_rd;
						rom_address_q <= res_rom;
						rom_valid_q   <= res_rom_vld;
					end
				end
				ST_RAM_RD: begin
					out_valid_q   <= 1'b1;
					read_data_q   <= ram_rdata;
					rom_address_q <= '0;
					rom_valid_q   <= 1'b0;
					state_q       <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.read_data   = read_data_q;
	assign rsp.rom_address = rom_address_q;
	assign rsp.rom_valid   = rom_valid_q;

endmodule

@@ test/testbench.sv @@
// Self-checking bench for the auto-incrementing pointer memory card.
// Drives bus words with random gaps and stalls and checks each response against a predictor.
// Depends on apmc_pkg, apmc_ifs and the card RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import apmc_pkg::*;

	localparam int unsigned RAM_BITS    = 20;
	localparam int unsigned CYCLE_LIMIT = 4_000_000;
	localparam int unsigned LONG_HOLD   = 150;

	typedef struct packed {
		op_t               opcode;
		logic [ADDR_W-1:0] address;
		logic [BYTE_W-1:0] write_data;
	} bus_op_t;

	typedef struct packed {
		logic [BYTE_W-1:0]     read_data;
		logic [ROM_ADDR_W-1:0] rom_address;
		logic                  rom_valid;
	} card_word_t;

	logic clk = 1'b0;
	logic arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [BYTE_W-1:0]    cfg_wdata;

	apmc_req_if req_ch ();
	apmc_rsp_if rsp_ch ();

	autoinc_pointer_memory_card #(.RAM_ADDR_BITS(RAM_BITS)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	// predicted card state
	logic [BYTE_W-1:0] ram_img [logic [RAM_BITS-1:0]];
	logic [PTR_W-1:0]  base_ptr;
	logic [PTR_W-1:0]  live_ptr;
	logic [BYTE_W-1:0] win_reg [16];
	logic [BYTE_W-1:0] bank_high;
	logic              alt_mode;
	logic [SLOT_W-1:0] slot_no;

	bus_op_t    bus_ops [$];
	card_word_t awaited_words [$];
	int unsigned items_queued   = 0;
	int unsigned words_received = 0;
	int unsigned fault_cnt      = 0;
	int unsigned cycle_cnt      = 0;
	int unsigned req_gap_max    = 0;
	int unsigned rsp_stall_max  = 0;
	int unsigned hold_left      = 0;
	logic        hold_go        = 1'b0;
	int unsigned gap_n          = 0;
	int unsigned stall_n        = 0;

	// clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// pointer copy in the register window, high byte merged with the bank mask
	function automatic void mirror_ptr(logic [PTR_W-1:0] p);
		win_reg[REG_PTR_LO]  = p[7:0];
		win_reg[REG_PTR_MID] = p[15:8];
		win_reg[REG_PTR_HI]  = p[23:16] | bank_high;
	endfunction

	function automatic void bump_live();
		live_ptr = live_ptr + 1'b1;
		mirror_ptr(live_ptr);
	endfunction

	// expected response word for one bus word; updates the predicted state
	function automatic card_word_t card_predict(bus_op_t r);
		card_word_t w;
		logic [REG_IDX_W-1:0] idx;
		logic [RAM_BITS-1:0]  ram_a;
		logic                 bank_sw;
		w = '0;
		idx = r.address[REG_IDX_W-1:0];
		ram_a = live_ptr[RAM_BITS-1:0];
		bank_sw = alt_mode && win_reg[REG_BANK][0];
		case (r.opcode)
			OP_REG_RD: begin
				if (idx == REG_RAM) begin
					w.read_data = ram_img.exists(ram_a) ? ram_img[ram_a] : RAM_FILL;
					bump_live();
				end else begin
					w.read_data = win_reg[idx];
				end
			end
			OP_REG_WR: begin
				if (idx <= REG_PTR_HI) begin
					base_ptr[idx*8 +: 8] = r.write_data;
					live_ptr = base_ptr;
					mirror_ptr(base_ptr);
				end else if (idx == REG_RAM) begin
					ram_img[ram_a] = r.write_data;
					bump_live();
				end else begin
					win_reg[idx] = r.write_data;
				end
			end
			OP_SLOT_ROM: begin
				w.rom_address = ROM_ADDR_W'({slot_no, r.address[7:0]})
					+ (bank_sw ? SLOT_BANK_OFS : '0);
				w.rom_valid = 1'b1;
			end
			OP_EXP_ROM: begin
				w.rom_address = ROM_ADDR_W'(r.address) + (bank_sw ? EXP_BANK_BASE : EXP_ROM_BASE);
				w.rom_valid = 1'b1;
			end
			default: ;
		endcase
		return w;
	endfunction

	// request side: takes pending words, predicts on acceptance
	always @(posedge clk) begin : req_side
		bus_op_t nxt;
		bus_op_t cur;
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				cur.opcode = req_ch.opcode;
				cur.address = req_ch.address;
				cur.write_data = req_ch.write_data;
				awaited_words.push_back(card_predict(cur));
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (gap_n != 0) begin
					req_ch.valid <= 1'b0;
					gap_n--;
				end else if (bus_ops.size() != 0) begin
					nxt = bus_ops.pop_front();
					req_ch.valid <= 1'b1;
					req_ch.opcode <= nxt.opcode;
					req_ch.address <= nxt.address;
					req_ch.write_data <= nxt.write_data;
					gap_n = $urandom_range(0, req_gap_max);
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, counted here
	always @(posedge clk) begin
		if (hold_go)
			hold_left <= LONG_HOLD;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	// response side: random stalls, compare against the oldest expectation
	always @(posedge clk) begin : rsp_side
		card_word_t got;
		card_word_t want;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				got.read_data = rsp_ch.read_data;
				got.rom_address = rsp_ch.rom_address;
				got.rom_valid = rsp_ch.rom_valid;
				words_received++;
				if (awaited_words.size() == 0) begin
					fault_cnt++;
					if (fault_cnt <= 10)
						$display("%0t: unexpected word: read_data %h rom_address %h rom_valid %b",
							$time, got.read_data, got.rom_address, got.rom_valid);
				end else begin
					want = awaited_words.pop_front();
					if (got.read_data !== want.read_data || got.rom_address !== want.rom_address
							|| got.rom_valid !== want.rom_valid) begin
						fault_cnt++;
						if (fault_cnt <= 10)
							$display("%0t: mismatch (exp/got): read_data %h/%h rom_address %h/%h rom_valid %b/%b",
								$time, want.read_data, got.read_data, want.rom_address,
								got.rom_address, want.rom_valid, got.rom_valid);
					end
				end
				stall_n = $urandom_range(0, rsp_stall_max);
			end
			if (hold_left != 0) begin
				rsp_ch.ready <= 1'b0;
			end else if (stall_n != 0) begin
				rsp_ch.ready <= 1'b0;
				if (rsp_ch.valid)
					stall_n--;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	task automatic push_op(op_t op, logic [ADDR_W-1:0] addr, logic [BYTE_W-1:0] data);
		bus_op_t b;
		b.opcode = op;
		b.address = addr;
		b.write_data = data;
		bus_ops.push_back(b);
		items_queued++;
	endtask

	// register address, upper bits sometimes set since only the low nibble decodes
	function automatic logic [ADDR_W-1:0] reg_addr(logic [REG_IDX_W-1:0] idx);
		logic [ADDR_W-1:0] a;
		a = $urandom_range(0, 1) ? ADDR_W'($urandom) : '0;
		a[REG_IDX_W-1:0] = idx;
		return a;
	endfunction

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		case (idx)
			CFG_BANK_HIGH: bank_high = val;
			CFG_ALT_MODE:  alt_mode = val[0];
			CFG_SLOT:      slot_no = val[SLOT_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_card(logic [BYTE_W-1:0] bank, logic alt, logic [SLOT_W-1:0] slot);
		cfg_write(CFG_BANK_HIGH, bank);
		cfg_write(CFG_ALT_MODE, BYTE_W'(alt));
		cfg_write(CFG_SLOT, BYTE_W'(slot));
	endtask

	// wait for every response word, then let the card settle
	task automatic wait_drained();
		while (words_received < items_queued)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// mostly pointer set-ups followed by data port runs, with ROM reads and noise
	task automatic queue_random(int unsigned n);
		int unsigned stop_at;
		int unsigned run;
		int unsigned k;
		int unsigned first;
		logic [PTR_W-1:0]     p;
		logic [REG_IDX_W-1:0] idx;
		stop_at = items_queued + n;
		while (items_queued < stop_at) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: begin
					p = PTR_W'($urandom);
					case ($urandom_range(0, 3))
						0: p[RAM_BITS-1:0] = RAM_BITS'($urandom_range(0, 63));
						1: p[RAM_BITS-1:0] = {RAM_BITS{1'b1}} - RAM_BITS'($urandom_range(0, 63));
						2: p = {PTR_W{1'b1}} - PTR_W'($urandom_range(0, 7));
						default: ;
					endcase
					if ($urandom_range(0, 3) == 0) begin
						push_op(OP_REG_WR, reg_addr(REG_PTR_LO), p[7:0]);
					end else begin
						first = $urandom_range(0, 2);
						for (k = 0; k < 3; k++) begin
							idx = REG_IDX_W'((first + k) % 3);
							push_op(OP_REG_WR, reg_addr(idx), p[idx*8 +: 8]);
						end
					end
					run = $urandom_range(1, 8);
					for (k = 0; k < run; k++) begin
						case ($urandom_range(0, 4))
							0, 1: push_op(OP_REG_WR, reg_addr(REG_RAM), BYTE_W'($urandom));
							2, 3: push_op(OP_REG_RD, reg_addr(REG_RAM), BYTE_W'($urandom));
							default: push_op(OP_REG_RD,
								reg_addr(REG_IDX_W'($urandom_range(0, 2))), BYTE_W'($urandom));
						endcase
					end
				end
				6: push_op($urandom_range(0, 1) ? OP_SLOT_ROM : OP_EXP_ROM,
					ADDR_W'($urandom), BYTE_W'($urandom));
				7: begin
					idx = REG_IDX_W'($urandom_range(REG_RAM + 1, REG_BANK));
					push_op($urandom_range(0, 1) ? OP_REG_WR : OP_REG_RD, reg_addr(idx),
						BYTE_W'($urandom));
				end
				default: push_op(op_t'($urandom_range(0, 3)), ADDR_W'($urandom),
					BYTE_W'($urandom));
			endcase
		end
	endtask

	// stimulus
	initial begin
		req_ch.valid = 1'b0;
		req_ch.opcode = OP_REG_RD;
		req_ch.address = '0;
		req_ch.write_data = '0;
		rsp_ch.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = CFG_BANK_HIGH;
		cfg_wdata = '0;
		arst_n = 1'b0;
		base_ptr = '0;
		live_ptr = '0;
		win_reg = '{default: '0};
		bank_high = BANK_HIGH_RST;
		alt_mode = 1'b0;
		slot_no = SLOT_RST;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: window reads, data port, pointer wrap, ROM map corners
		push_op(OP_REG_RD, {7'h7F, REG_PTR_HI}, 8'hFF);
		push_op(OP_REG_RD, {7'h00, REG_RAM}, 8'h00);
		push_op(OP_REG_RD, {7'h00, REG_PTR_HI}, 8'h00);
		push_op(OP_REG_WR, {7'h00, REG_PTR_LO}, 8'hFF);
		push_op(OP_REG_WR, {7'h7F, REG_PTR_MID}, 8'hFF);
		push_op(OP_REG_WR, {7'h55, REG_PTR_HI}, 8'hFF);
		push_op(OP_REG_WR, {7'h00, REG_RAM}, 8'hA5);
		push_op(OP_REG_RD, {7'h00, REG_PTR_LO}, 8'h00);
		push_op(OP_REG_RD, {7'h00, REG_PTR_HI}, 8'h00);
		push_op(OP_REG_WR, {7'h00, REG_PTR_LO}, 8'hFF);
		push_op(OP_REG_RD, {7'h7F, REG_RAM}, 8'hFF);
		push_op(OP_REG_WR, {7'h00, REG_BANK}, 8'h01);
		push_op(OP_REG_WR, {7'h00, REG_IDX_W'(4)}, 8'h00);
		push_op(OP_REG_WR, {7'h00, REG_IDX_W'(14)}, 8'hFF);
		push_op(OP_REG_RD, {7'h00, REG_IDX_W'(14)}, 8'h00);
		push_op(OP_REG_RD, {7'h00, REG_BANK}, 8'h00);
		push_op(OP_SLOT_ROM, 11'h000, 8'h00);
		push_op(OP_SLOT_ROM, 11'h7FF, 8'hFF);
		push_op(OP_EXP_ROM, 11'h000, 8'h00);
		push_op(OP_EXP_ROM, 11'h7FF, 8'hFF);
		wait_drained();

		// bank switching on; register 2 holds its old copy until the pointer moves
		set_card(8'h00, 1'b1, 3'd7);
		push_op(OP_REG_RD, {7'h00, REG_PTR_HI}, 8'h00);
		push_op(OP_SLOT_ROM, 11'h0FF, 8'h00);
		push_op(OP_EXP_ROM, 11'h7FF, 8'h00);
		push_op(OP_REG_WR, {7'h00, REG_PTR_HI}, 8'h00);
		push_op(OP_REG_RD, {7'h00, REG_PTR_HI}, 8'h00);
		push_op(OP_REG_WR, {7'h00, REG_BANK}, 8'hFE);
		push_op(OP_SLOT_ROM, 11'h0FF, 8'h00);
		push_op(OP_EXP_ROM, 11'h000, 8'h00);
		wait_drained();

		// random phases, settings swept; each phase pauses halfway until drained
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin
					set_card(8'hFF, 1'b1, 3'd0);
					req_gap_max <= 15;
					rsp_stall_max <= 15;
				end
				1: begin
					set_card(8'h00, 1'b0, 3'd7);
					req_gap_max <= 0;
					rsp_stall_max <= 0;
					@(posedge clk);
					hold_go <= 1'b1;
					@(posedge clk);
					hold_go <= 1'b0;
				end
				2: begin
					set_card(BANK_HIGH_RST, 1'b1, SLOT_RST);
					req_gap_max <= 15;
					rsp_stall_max <= 0;
				end
				3: begin
					set_card(8'h0F, 1'b1, 3'd3);
					req_gap_max <= 0;
					rsp_stall_max <= 15;
				end
				default: begin
					set_card(BYTE_W'($urandom), 1'($urandom), SLOT_W'($urandom));
					req_gap_max <= $urandom_range(0, 1) * 15;
					rsp_stall_max <= $urandom_range(0, 1) * 15;
				end
			endcase
			queue_random(125);
			wait_drained();
			queue_random(125);
			wait_drained();
		end

		if (fault_cnt == 0 && awaited_words.size() == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

@@ files.f @@
rtl/apmc_pkg.sv
rtl/apmc_ifs.sv
rtl/apmc_ram.sv
rtl/apmc_regs.sv
rtl/autoinc_pointer_memory_card.sv
test/testbench.sv
